// ===== hw/rtl/kcb_pkg.sv =====
package kcb_pkg;

  localparam int MAX_ENTRIES = 32;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int LIM_W       = 6;
  localparam int CMP_W       = (CNT_W > LIM_W) ? CNT_W : LIM_W;
  localparam int KEY_W       = 64;
  localparam int SEQ_W       = 64;
  localparam int ENTRY_W     = 1 + KEY_W + SEQ_W;

  localparam logic [LIM_W-1:0] LIMIT_RST = LIM_W'(32);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_APPENDED = 2'd0,
    ST_MERGED   = 2'd1,
    ST_FULL     = 2'd2,
    ST_DRAINED  = 2'd3
  } status_e;

  typedef enum logic {
    OP_PUSH  = 1'b0,
    OP_FLUSH = 1'b1
  } op_e;

  typedef struct packed {
    op_e                     operation;
    logic                    event_kind;
    logic signed [KEY_W-1:0] blk_key;
    logic [SEQ_W-1:0]        seq_number;
  } item_t;

  typedef struct packed {
    status_e                 status;
    logic                    out_kind;
    logic signed [KEY_W-1:0] out_key;
    logic [SEQ_W-1:0]        out_seq;
    logic                    last_entry;
  } result_t;

endpackage

// ===== hw/rtl/kcb_if.sv =====
interface kcb_in_if import kcb_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    operation;
  logic                    event_kind;
  logic signed [KEY_W-1:0] blk_key;
  logic [SEQ_W-1:0]        seq_number;

  modport source (output valid, operation, event_kind, blk_key, seq_number, input ready);
  modport sink (input valid, operation, event_kind, blk_key, seq_number, output ready);
endinterface

interface kcb_out_if import kcb_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [1:0]              status;
  logic                    out_kind;
  logic signed [KEY_W-1:0] out_key;
  logic [SEQ_W-1:0]        out_seq;
  logic                    last_entry;

  modport source (output valid, status, out_kind, out_key, out_seq, last_entry, input ready);
  modport sink (input valid, status, out_kind, out_key, out_seq, last_entry, output ready);
endinterface

interface kcb_cfg_if import kcb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LIM_W-1:0] entry_limit;

  modport source (output valid, entry_limit, input ready);
  modport sink (input valid, entry_limit, output ready);
endinterface

// ===== hw/rtl/kcb_ram.sv =====
module kcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/kcb_front.sv =====
module kcb_front import kcb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  kcb_in_if.sink   in_i,
  output item_t    item_o,
  output logic     item_vld_o,
  input  logic     item_pop_i
);

  item_t             slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] fill_q, fill_d;
  logic              push, pop;
  item_t             item_in;

  // classify the incoming beat: push-only fields pass through untouched
  always_comb begin
    item_in.operation  = (in_i.operation == 1'b1) ? OP_FLUSH : OP_PUSH;
    item_in.event_kind = in_i.event_kind;
    item_in.blk_key    = in_i.blk_key;
    item_in.seq_number = in_i.seq_number;
  end

  assign in_i.ready = (fill_q != QCNT_W'(QUEUE_DEPTH));
  assign item_vld_o = (fill_q != '0);
  assign item_o     = slot_q[rd_ptr_q];
  assign push       = in_i.valid && in_i.ready;
  assign pop        = item_pop_i && item_vld_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
    end
    if (push && !pop) begin
      fill_d = fill_q + QCNT_W'(1);
    end else if (pop && !push) begin
      fill_d = fill_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

// ===== hw/rtl/kcb_back.sv =====
module kcb_back import kcb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  item_t     item_i,
  input  logic      item_vld_i,
  output logic      item_pop_o,
  kcb_cfg_if.sink   cfg_i,
  kcb_out_if.source out_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SEND
  } state_e;

  state_e                  state_q, state_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [CNT_W-1:0]        drain_q, drain_d;
  logic                    out_vld_q, out_vld_d;
  result_t                 res_q, res_d;
  logic [LIM_W-1:0]        limit_q;
  logic signed [KEY_W-1:0] key_q [MAX_ENTRIES];

  logic [MAX_ENTRIES-1:0]  hit_vec;
  logic [IDX_W-1:0]        hit_idx;
  logic                    hit, full, out_free, push_go, append;
  logic                    ram_we, ram_re;
  logic [IDX_W-1:0]        ram_waddr;
  logic [ENTRY_W-1:0]      ram_wdata, ram_rdata;

  // limit register, takes a write on any cycle
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RST;
    end else if (cfg_i.valid) begin
      limit_q <= cfg_i.entry_limit;
    end
  end

  // parallel key compare, keys are unique so the hit vector is one-hot
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit_vec[i] = (CNT_W'(i) < count_q) && (key_q[i] == item_i.blk_key);
      if (hit_vec[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
  end

  assign hit      = |hit_vec;
  assign full     = (CMP_W'(count_q) >= CMP_W'(limit_q)) ||
                    (CMP_W'(count_q) >= CMP_W'(MAX_ENTRIES));
  assign out_free = !out_vld_q || out_o.ready;
  assign push_go  = (state_q == S_IDLE) && item_vld_i &&
                    (item_i.operation == OP_PUSH) && out_free;
  assign append   = push_go && !hit && !full;

  assign ram_we    = push_go && (hit || !full);
  assign ram_waddr = hit ? hit_idx : count_q[IDX_W-1:0];
  assign ram_wdata = {item_i.event_kind, item_i.blk_key, item_i.seq_number};
  assign ram_re    = (state_q == S_READ);

  always_comb begin
    item_pop_o = 1'b0;
    if (state_q == S_IDLE && item_vld_i) begin
      item_pop_o = (item_i.operation == OP_FLUSH) || out_free;
    end
  end

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    drain_d   = drain_q;
    out_vld_d = out_vld_q && !out_o.ready;
    res_d     = res_q;
    case (state_q)
      S_IDLE: begin
        if (item_vld_i && item_i.operation == OP_FLUSH) begin
          drain_d = '0;
          if (count_q != '0) begin
            state_d = S_READ;
          end
        end else if (push_go) begin
          out_vld_d        = 1'b1;
          res_d.out_kind   = item_i.event_kind;
          res_d.out_key    = item_i.blk_key;
          res_d.out_seq    = item_i.seq_number;
          res_d.last_entry = 1'b0;
          if (hit) begin
            res_d.status = ST_MERGED;
          end else if (full) begin
            res_d.status = ST_FULL;
          end else begin
            res_d.status = ST_APPENDED;
            count_d      = count_q + CNT_W'(1);
          end
        end
      end
      S_READ: begin
        state_d = S_SEND;
      end
      S_SEND: begin
        if (out_free) begin
          out_vld_d        = 1'b1;
          res_d.status     = ST_DRAINED;
          res_d.out_kind   = ram_rdata[ENTRY_W-1];
          res_d.out_key    = ram_rdata[KEY_W+SEQ_W-1:SEQ_W];
          res_d.out_seq    = ram_rdata[SEQ_W-1:0];
          res_d.last_entry = (drain_q == count_q - CNT_W'(1));
          if (drain_q == count_q - CNT_W'(1)) begin
            count_d = '0;
            state_d = S_IDLE;
          end else begin
            drain_d = drain_q + CNT_W'(1);
            state_d = S_READ;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      drain_q   <= '0;
      out_vld_q <= 1'b0;
      res_q     <= '0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      drain_q   <= drain_d;
      out_vld_q <= out_vld_d;
      res_q     <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (append) begin
      key_q[count_q[IDX_W-1:0]] <= item_i.blk_key;
    end
  end

  kcb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (drain_q[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign out_o.valid      = out_vld_q;
  assign out_o.status     = res_q.status;
  assign out_o.out_kind   = res_q.out_kind;
  assign out_o.out_key    = res_q.out_key;
  assign out_o.out_seq    = res_q.out_seq;
  assign out_o.last_entry = res_q.last_entry;

endmodule

// ===== hw/rtl/key_coalescing_event_buffer.sv =====
// channel  | dir | beat contents
// ---------+-----+------------------------------------------------
// in_i     | in  | operation, event_kind, blk_key, seq_number
// out_o    | out | status, out_kind, out_key, out_seq, last_entry
// cfg_i    | in  | entry_limit
//
// in the execute side a push is taken once the output register is free:
// the key compare against all held entries and the table update happen in the same cycle
// a flush drains each held entry with one entry ram read and then one output load,
// after the flush beat is picked up; an empty flush gives no beat
// reset clears the entry count, the limit (to 32), the queue and the output valid
// the two-slot queue keeps accepting beats until full while the execute side stalls on out_o
module key_coalescing_event_buffer import kcb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  kcb_in_if.sink    in_i,
  kcb_out_if.source out_o,
  kcb_cfg_if.sink   cfg_i
);

  // queued beat handed from the front side to the execute side
  item_t item;
  logic  item_vld;
  logic  item_pop;

  // front side: takes beats, decodes the operation, buffers them
  kcb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .item_o     (item),
    .item_vld_o (item_vld),
    .item_pop_i (item_pop)
  );

  // execute side: key table, merge / append / reject, flush drain,
  // limit register and the output register
  kcb_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item),
    .item_vld_i (item_vld),
    .item_pop_o (item_pop),
    .cfg_i      (cfg_i),
    .out_o      (out_o)
  );

endmodule

// ===== tb/testbench.sv =====
module testbench import kcb_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 500_000;
  // cycles to let an empty flush pass through the input queue before a limit write
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES = 40;
  localparam int POOL_SIZE = 40;

  logic clk_i = 1'b0;
  logic rst_ni;

  kcb_in_if  in_if ();
  kcb_out_if out_if ();
  kcb_cfg_if cfg_if ();

  key_coalescing_event_buffer uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #10 clk_i = ~clk_i;

  // shadow of the event table
  logic signed [KEY_W-1:0] held_key [MAX_ENTRIES];
  logic                    held_kind [MAX_ENTRIES];
  logic [SEQ_W-1:0]        held_seq [MAX_ENTRIES];
  int unsigned             held_count;
  logic [LIM_W-1:0]        limit_reg;

  // beats the block still owes us, oldest first
  result_t due_results[$];

  int  src_idle_pct;
  int  sink_idle_pct;
  int  hold_req;
  int  hold_left;
  bit  failed;

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic void owe_result(status_e st, logic kind, logic signed [KEY_W-1:0] key,
                                     logic [SEQ_W-1:0] seq, logic last);
    result_t r;
    r.status     = st;
    r.out_kind   = kind;
    r.out_key    = key;
    r.out_seq    = seq;
    r.last_entry = last;
    due_results = {due_results, r};
  endfunction

  // last write wins per key, new keys in order of first appearance
  function automatic void predict_event_outcome(item_t it);
    int unsigned lim;
    bit          hit;
    hit = 1'b0;
    if (it.operation == OP_FLUSH) begin
      for (int unsigned i = 0; i < held_count; i++)
        owe_result(ST_DRAINED, held_kind[i], held_key[i], held_seq[i], i + 1 == held_count);
      held_count = 0;
      return;
    end
    lim = (limit_reg > MAX_ENTRIES) ? MAX_ENTRIES : limit_reg;
    for (int unsigned i = 0; i < held_count && !hit; i++) begin
      if (held_key[i] == it.blk_key) begin
        held_kind[i] = it.event_kind;
        held_seq[i]  = it.seq_number;
        hit = 1'b1;
      end
    end
    if (hit) begin
      owe_result(ST_MERGED, it.event_kind, it.blk_key, it.seq_number, 1'b0);
    end else if (held_count >= lim) begin
      owe_result(ST_FULL, it.event_kind, it.blk_key, it.seq_number, 1'b0);
    end else begin
      held_key[held_count]  = it.blk_key;
      held_kind[held_count] = it.event_kind;
      held_seq[held_count]  = it.seq_number;
      held_count++;
      owe_result(ST_APPENDED, it.event_kind, it.blk_key, it.seq_number, 1'b0);
    end
  endfunction

  // called at a falling edge, returns at the falling edge after the beat is taken
  // valid stays high on return so back-to-back beats never drop it
  task automatic send_item(item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.operation  <= it.operation;
    in_if.event_kind <= it.event_kind;
    in_if.blk_key    <= it.blk_key;
    in_if.seq_number <= it.seq_number;
    do @(posedge clk_i); while (!in_if.ready);
    predict_event_outcome(it);
    @(negedge clk_i);
  endtask

  task automatic push_event(logic kind, logic signed [KEY_W-1:0] key, logic [SEQ_W-1:0] seq);
    item_t it;
    it.operation  = OP_PUSH;
    it.event_kind = kind;
    it.blk_key    = key;
    it.seq_number = seq;
    send_item(it);
  endtask

  // push-only fields carry junk on a flush, the block must ignore them
  task automatic flush_table();
    item_t it;
    it.operation  = OP_FLUSH;
    it.event_kind = 1'($urandom_range(1));
    it.blk_key    = rand64();
    it.seq_number = rand64();
    send_item(it);
  endtask

  // block idle: nothing owed and any empty flush long gone
  task automatic settle();
    in_if.valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_limit(logic [LIM_W-1:0] value);
    settle();
    cfg_if.valid       <= 1'b1;
    cfg_if.entry_limit <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    limit_reg = value;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // reset limit of 32, key and sequence extremes, merge in place, empty flushes
  task automatic test_extremes_and_merge();
    flush_table();
    push_event(1'b0, 64'sh8000_0000_0000_0000, 64'h0);
    push_event(1'b1, 64'sh7fff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff);
    push_event(1'b0, 64'sh0, 64'h5555_aaaa_5555_aaaa);
    push_event(1'b1, -64'sd1, 64'haaaa_5555_aaaa_5555);
    push_event(1'b1, 64'sh8000_0000_0000_0000, 64'h1234_5678_9abc_def0);
    flush_table();
    flush_table();
  endtask

  // merge still works with the table at its limit
  task automatic test_limit_of_one();
    write_limit(LIM_W'(1));
    push_event(1'b0, 64'sd17, 64'd1);
    push_event(1'b1, 64'sd18, 64'd2);
    push_event(1'b1, 64'sd17, 64'd3);
    flush_table();
  endtask

  // zero limit rejects every new key
  task automatic test_limit_of_zero();
    write_limit(LIM_W'(0));
    push_event(1'b1, 64'sd99, 64'd4);
    flush_table();
  endtask

  // held entries survive a lower limit, only new keys bounce
  task automatic test_limit_lowered_below_count();
    write_limit(LIM_W'(32));
    push_event(1'b0, 64'sd1, 64'd10);
    push_event(1'b1, 64'sd2, 64'd11);
    push_event(1'b0, 64'sd3, 64'd12);
    write_limit(LIM_W'(2));
    push_event(1'b0, 64'sd4, 64'd13);
    push_event(1'b1, 64'sd3, 64'd14);
    flush_table();
  endtask

  // mostly keys from a small pool so merges are common, some fresh keys to fill the table
  task automatic test_random_traffic(int n_items, int flush_pct, int fresh_pct);
    logic signed [KEY_W-1:0] key_pool [POOL_SIZE];
    int                      pool_used;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = rand64();
    case ($urandom_range(2))
      0: key_pool[0] = 64'sh8000_0000_0000_0000;
      1: key_pool[0] = 64'sh7fff_ffff_ffff_ffff;
      default: key_pool[0] = -64'sd1;
    endcase
    pool_used = $urandom_range(POOL_SIZE - 1, 3);
    for (int n = 0; n < n_items; n++) begin
      if ($urandom_range(99) < flush_pct)
        flush_table();
      else if ($urandom_range(99) < fresh_pct)
        push_event(1'($urandom_range(1)), rand64(), rand64());
      else
        push_event(1'($urandom_range(1)), key_pool[$urandom_range(pool_used - 1)], rand64());
    end
  endtask

  // receiver side, long hold-off counted down here
  always @(negedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // every accepted result beat against the oldest one owed
  always @(posedge clk_i) begin
    result_t exp_r;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (due_results.size() == 0) begin
        $error("unexpected result beat: status %0d key %h seq %h",
               out_if.status, out_if.out_key, out_if.out_seq);
        failed = 1'b1;
      end else begin
        exp_r = due_results.pop_front();
        if (out_if.status !== exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, out_if.status);
          failed = 1'b1;
        end
        if (out_if.out_kind !== exp_r.out_kind) begin
          $error("out_kind: expected %0d, actual %0d", exp_r.out_kind, out_if.out_kind);
          failed = 1'b1;
        end
        if (out_if.out_key !== exp_r.out_key) begin
          $error("out_key: expected %h, actual %h", exp_r.out_key, out_if.out_key);
          failed = 1'b1;
        end
        if (out_if.out_seq !== exp_r.out_seq) begin
          $error("out_seq: expected %h, actual %h", exp_r.out_seq, out_if.out_seq);
          failed = 1'b1;
        end
        if (out_if.last_entry !== exp_r.last_entry) begin
          $error("last_entry: expected %0d, actual %0d", exp_r.last_entry, out_if.last_entry);
          failed = 1'b1;
        end
      end
    end
  end

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("key_coalescing_event_buffer regression: fail");
    $finish;
  end

  initial begin
    failed        = 1'b0;
    hold_req      = 0;
    hold_left     = 0;
    src_idle_pct  = 33;
    sink_idle_pct = 47;
    held_count    = 0;
    limit_reg     = LIMIT_RST;
    rst_ni        = 1'b0;
    in_if.valid        = 1'b0;
    in_if.operation    = OP_PUSH;
    in_if.event_kind   = 1'b0;
    in_if.blk_key      = '0;
    in_if.seq_number   = '0;
    out_if.ready       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.entry_limit = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // sender idles more lightly than the receiver
    test_extremes_and_merge();
    test_limit_of_one();
    test_limit_of_zero();
    test_limit_lowered_below_count();
    write_limit(LIM_W'(32));
    test_random_traffic(70, 4, 30);
    // above the table size acts as the table size, fresh keys push it to full
    write_limit(LIM_W'(63));
    test_random_traffic(70, 2, 80);

    // roles swapped
    settle();
    src_idle_pct  = 47;
    sink_idle_pct = 33;
    write_limit(LIM_W'(1));
    test_random_traffic(50, 10, 30);
    write_limit(LIM_W'(0));
    test_random_traffic(30, 10, 30);
    write_limit(LIM_W'($urandom_range(31, 2)));
    // receiver blocks long enough for the input queue to fill and stall the sender
    hold_req = 300;
    test_random_traffic(70, 5, 40);

    // no idling on either side
    settle();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    write_limit(LIM_W'($urandom_range(63)));
    test_random_traffic(70, 5, 30);
    write_limit(LIM_W'(32));
    test_random_traffic(60, 8, 30);

    settle();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (!failed && due_results.size() == 0) begin
      $display("key_coalescing_event_buffer regression: pass");
    end else begin
      $display("key_coalescing_event_buffer regression: fail");
    end
    $finish;
  end

endmodule
